// ===== rtl/medt_pkg.sv =====
// ============================================================================
// medt_pkg - shared types and constants
// Distance widths, reset values and the tag that rides along the root chain.
// ============================================================================
package medt_pkg;

  // Width and ceiling of a distance in Q9.16 metres
  localparam int unsigned DIST_W = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = 25'h1FF_FFFF;

  // Reset value of the per-frame start minimum: 100 m in Q9.16
  localparam logic [DIST_W-1:0] MIN_START_RESET = 25'd6553600;

  // Side information of one item, carried from cell to cell
  typedef struct packed {
    logic part_valid;
    logic frame_last;
    logic sat;
  } medt_tag_t;

endpackage

// ===== rtl/medt_sqacc.sv =====
// ============================================================================
// medt_sqacc - absolute differences and sum of squares
// Take the three difference magnitudes, keep their low DW bits, flag any past
// the range, sum their squares on one shared multiplier, one axis per cycle.
// ============================================================================
module medt_sqacc
  import medt_pkg::*;
#(
  parameter int unsigned CW = 24,
  parameter int unsigned DW = 24,
  parameter int unsigned SW = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] tool_x,
  input  logic signed [CW-1:0] tool_y,
  input  logic signed [CW-1:0] tool_z,
  input  logic signed [CW-1:0] part_x,
  input  logic signed [CW-1:0] part_y,
  input  logic signed [CW-1:0] part_z,
  input  medt_tag_t            tag_in,
  output logic                 done,
  output logic [SW-1:0]        sum,
  output medt_tag_t            tag
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQX  = 3'd1;
  localparam logic [2:0] ST_SQY  = 3'd2;
  localparam logic [2:0] ST_SQZ  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]          step;
  logic [2:0]          step_next;
  logic [DW-1:0]       comp [3];
  logic [DW-1:0]       comp_next [3];
  logic                sat_next;
  logic [DW-1:0]       sel;
  logic [2*DW-1:0]     prod;
  logic [SW-1:0]       acc;
  logic signed [CW:0]  diff [3];
  logic [CW:0]         mag [3];
  logic signed [CW-1:0] pt [3];
  logic signed [CW-1:0] tl [3];

  assign pt[0] = part_x;
  assign pt[1] = part_y;
  assign pt[2] = part_z;
  assign tl[0] = tool_x;
  assign tl[1] = tool_y;
  assign tl[2] = tool_z;

  // Magnitude of each axis difference; anything past the output range saturates
  always_comb begin
    sat_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {pt[i][CW-1], pt[i]} - {tl[i][CW-1], tl[i]};
      mag[i]  = diff[i][CW] ? (CW+1)'(-diff[i]) : (CW+1)'(diff[i]);
      comp_next[i] = mag[i][DW-1:0];
      if (64'(mag[i]) > 64'(DIST_MAX)) begin
        sat_next = 1'b1;
      end
    end
  end

  always_comb begin
    case (step)
      ST_SQX:  sel = comp[0];
      ST_SQY:  sel = comp[1];
      ST_SQZ:  sel = comp[2];
      default: sel = '0;
    endcase
  end

  always_comb begin
    case (step)
      ST_IDLE: step_next = start ? ST_SQX : ST_IDLE;
      ST_SQX:  step_next = ST_SQY;
      ST_SQY:  step_next = ST_SQZ;
      ST_SQZ:  step_next = ST_ACC;
      ST_ACC:  step_next = ST_DONE;
      default: step_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step == ST_IDLE && start) begin
      comp    <= comp_next;
      tag     <= '{part_valid: tag_in.part_valid, frame_last: tag_in.frame_last,
                   sat: sat_next};
      acc     <= '0;
    end
    prod <= sel * sel;
    if (step == ST_SQY || step == ST_SQZ || step == ST_ACC) begin
      acc <= acc + SW'(prod);
    end
  end

  assign done = (step == ST_DONE);
  assign sum  = acc;

endmodule

// ===== rtl/medt_root_cell.sv =====
// ============================================================================
// medt_root_cell - one digit of the restoring square root
// Shift in two radicand bits, try the next root bit, hand the result on.
// ============================================================================
module medt_root_cell
  import medt_pkg::*;
#(
  parameter int unsigned RW = 25,
  parameter int unsigned SW = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          tok_in,
  input  medt_tag_t     tag_in,
  input  logic [RW+1:0] rem_in,
  input  logic [RW-1:0] root_in,
  input  logic [SW-1:0] rad_in,
  output logic          tok,
  output medt_tag_t     tag,
  output logic [RW+1:0] rem,
  output logic [RW-1:0] root,
  output logic [SW-1:0] rad
);

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          take;

  assign rem_sh = {rem_in[RW-1:0], rad_in[SW-1:SW-2]};
  assign trial  = {root_in, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (en) begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag  <= tag_in;
      rem  <= take ? rem_sh - trial : rem_sh;
      root <= {root_in[RW-2:0], take};
      rad  <= {rad_in[SW-3:0], 2'b00};
    end
  end

endmodule

// ===== rtl/min_euclidean_distance_tracker_unit.sv =====
// ============================================================================
// min_euclidean_distance_tracker_unit - 3D distance and per-frame minimum
// Distance from a tool point to a body point as a truncated integer square
// root in Q9.16, plus the running minimum over the valid points of a frame.
// ============================================================================
//
//  Channel  Signals                                Direction  Beat
//  -------  -------------------------------------  ---------  -------------------
//  in       in_valid/in_ready, tool_*, part_*,     sink       one point pair
//           part_valid, frame_last
//  out      out_valid/out_ready, distance,         source     one result
//           distance_valid, frame_minimum, result_last
//  cfg      cfg_wr_en, cfg_wr_data                 sink       min_start write
//
//  One beat is in flight at a time: from accept to out_valid it passes the
//  differences and three squares, then one root bit per digit cell down the
//  chain (RW = root width, 25 for 24-bit coordinates).
//  in_ready returns as the result lands in the output register, so a new
//  beat is taken while that result waits. A stalled output holds the chain
//  at its last cell; reset loads 100 m.
//
module min_euclidean_distance_tracker_unit
  import medt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] tool_x,
  input  logic signed [COORD_WIDTH-1:0] tool_y,
  input  logic signed [COORD_WIDTH-1:0] tool_z,
  input  logic signed [COORD_WIDTH-1:0] part_x,
  input  logic signed [COORD_WIDTH-1:0] part_y,
  input  logic signed [COORD_WIDTH-1:0] part_z,
  input  logic                          part_valid,
  input  logic                          frame_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DIST_W-1:0]             distance,
  output logic                          distance_valid,
  output logic [DIST_W-1:0]             frame_minimum,
  output logic                          result_last,
  input  logic                          cfg_wr_en,
  input  logic [DIST_W-1:0]             cfg_wr_data
);

  // Components are cut to DW bits, at most the distance width, before squaring
  localparam int unsigned DW = (COORD_WIDTH > DIST_W) ? DIST_W : COORD_WIDTH;
  localparam int unsigned SW = 2 * DW + 2;   // sum of three squares
  localparam int unsigned RW = SW / 2;       // root bits, one cell each

  logic              inflight;
  logic              accept;
  logic              adv;
  logic              take_out;
  logic [DIST_W-1:0] min_start;
  logic [DIST_W-1:0] running_minimum;
  logic [DIST_W-1:0] dist_next;
  logic [DIST_W-1:0] min_next;
  logic [31:0]       root_wide;

  logic              sq_done;
  logic [SW-1:0]     sq_sum;
  medt_tag_t         sq_tag;
  medt_tag_t         in_tag;

  // Chain taps: index 0 feeds the first cell, index RW is the last cell
  logic              tok_c  [RW+1];
  medt_tag_t         tag_c  [RW+1];
  logic [RW+1:0]     rem_c  [RW+1];
  logic [RW-1:0]     root_c [RW+1];
  logic [SW-1:0]     rad_c  [RW+1];

  assign in_ready = !inflight;
  assign accept   = in_valid && in_ready;
  assign in_tag   = '{part_valid: part_valid, frame_last: frame_last, sat: 1'b0};

  // Hold the chain while the finished root waits on a full output register
  assign adv      = !(tok_c[RW] && out_valid && !out_ready);
  assign take_out = tok_c[RW] && adv;

  medt_sqacc #(
    .CW (COORD_WIDTH),
    .DW (DW),
    .SW (SW)
  ) u_sqacc (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .tool_x (tool_x),
    .tool_y (tool_y),
    .tool_z (tool_z),
    .part_x (part_x),
    .part_y (part_y),
    .part_z (part_z),
    .tag_in (in_tag),
    .done   (sq_done),
    .sum    (sq_sum),
    .tag    (sq_tag)
  );

  assign tok_c[0]  = sq_done;
  assign tag_c[0]  = sq_tag;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign rad_c[0]  = sq_sum;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    medt_root_cell #(
      .RW (RW),
      .SW (SW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .tok_in  (tok_c[i]),
      .tag_in  (tag_c[i]),
      .rem_in  (rem_c[i]),
      .root_in (root_c[i]),
      .rad_in  (rad_c[i]),
      .tok     (tok_c[i+1]),
      .tag     (tag_c[i+1]),
      .rem     (rem_c[i+1]),
      .root    (root_c[i+1]),
      .rad     (rad_c[i+1])
    );
  end

  // Final distance: zero for a skipped point, saturate past the Q9.16 range
  assign root_wide = 32'(root_c[RW]);

  always_comb begin
    if (!tag_c[RW].part_valid) begin
      dist_next = '0;
    end else if (tag_c[RW].sat || root_wide > 32'(DIST_MAX)) begin
      dist_next = DIST_MAX;
    end else begin
      dist_next = root_wide[DIST_W-1:0];
    end
    // Replace only on a strictly smaller valid distance
    if (tag_c[RW].part_valid && dist_next < running_minimum) begin
      min_next = dist_next;
    end else begin
      min_next = running_minimum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight        <= 1'b0;
      out_valid       <= 1'b0;
      min_start       <= MIN_START_RESET;
      running_minimum <= MIN_START_RESET;
    end else begin
      if (cfg_wr_en) begin
        min_start <= cfg_wr_data;
      end
      if (accept) begin
        inflight <= 1'b1;
      end else if (take_out) begin
        inflight <= 1'b0;
      end
      if (take_out) begin
        out_valid       <= 1'b1;
        // Reload the start value once the frame closes
        running_minimum <= tag_c[RW].frame_last ? min_start : min_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      distance       <= dist_next;
      distance_valid <= tag_c[RW].part_valid;
      frame_minimum  <= min_next;
      result_last    <= tag_c[RW].frame_last;
    end
  end

endmodule
